// ----- hdl/pedc_pkg.sv -----
// shared constants, token codes and types for the postfix equation address decoder
// no dependencies; imported by the stack unit and the top level
`default_nettype none

package pedc_pkg;

    localparam int NUM_DEVICES = 8;
    localparam int MAX_TOKENS  = 32;
    localparam int ADDR_BITS   = 16;
    localparam int OUT_BITS    = 16;
    localparam int STACK_DEPTH = 16;

    localparam int EQ_PER_DEV = OUT_BITS + 1;
    localparam int STORE_SIZE = NUM_DEVICES * EQ_PER_DEV * MAX_TOKENS;
    localparam int TS_AW      = $clog2(STORE_SIZE);
    localparam int TOK_W      = 7;
    localparam int POS_W      = $clog2(MAX_TOKENS);
    localparam int SCNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int KBIT_W     = (OUT_BITS > 1) ? $clog2(OUT_BITS) : 1;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    typedef enum logic [2:0] {
        K_OPERAND = 3'd0,
        K_NOT     = 3'd1,
        K_AND     = 3'd2,
        K_OR      = 3'd3,
        K_XOR     = 3'd4,
        K_LOW     = 3'd5,
        K_HIGH    = 3'd6,
        K_END     = 3'd7
    } kind_t;

    typedef struct packed {
        logic  clear;
        logic  exec;
        kind_t kind;
        logic  opnd;
    } stk_ctrl_t;

    // token store location of one token: equations are laid out per device, then per role
    function automatic logic [TS_AW-1:0] tok_addr(input logic [2:0] dev,
                                                  input logic [4:0] role,
                                                  input logic [POS_W-1:0] pos);
        return TS_AW'((int'(dev) * EQ_PER_DEV + int'(role)) * MAX_TOKENS + int'(pos));
    endfunction

endpackage

`default_nettype wire

// ----- hdl/postfix_equation_address_decoder.sv -----
// postfix equation address decoder: token store ram, evaluation stack and sequencer
// a token write is taken while idle and gives no result; a resolve walks equations
// one token per cycle, with a load state before each equation, up to the done strobe
// (at most 8 chip selects and 16 address equations of 32 tokens), set by the single ram read port
// the done strobe lasts one cycle and cannot be held off; busy is already low while it is shown
// reset clears control state and device_count; the token store is undefined until written
`default_nettype none

module postfix_equation_address_decoder
    import pedc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [2:0]  device,
    input  wire logic [4:0]  equation_role,
    input  wire logic [4:0]  token_position,
    input  wire logic [2:0]  token_kind,
    input  wire logic [3:0]  operand_bit,
    input  wire logic [15:0] address,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,
    output logic             done,
    output logic             device_found,
    output logic [2:0]       device_index,
    output logic [15:0]      decoded_address
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EVAL
    } state_t;

    localparam logic [15:0] ADDR_MASK = 16'((32'h1 << ADDR_BITS) - 1);

    state_t              state_reg, state_next;
    logic                phase_reg, phase_next;      // 0 chip selects, 1 address equations
    logic [2:0]          dev_reg, dev_next;
    logic [KBIT_W-1:0]   k_reg, k_next;
    logic [POS_W-1:0]    cnt_reg, cnt_next;
    logic [TS_AW-1:0]    base_reg, base_next;
    logic [15:0]         addr_reg, addr_next;
    logic [3:0]          limit_reg, limit_next;
    logic                found_reg, found_next;
    logic [OUT_BITS-1:0] dec_reg, dec_next;
    logic                done_reg, done_next;
    logic [3:0]          devcnt_reg;

    logic              accept;
    logic              wr_en;
    logic [TS_AW-1:0]  wr_addr;
    logic [TOK_W-1:0]  wr_data;
    logic [TS_AW-1:0]  rd_addr;
    logic [TOK_W-1:0]  rd_data;
    logic [4:0]        role_cur;
    logic [TS_AW-1:0]  load_base;
    kind_t             tok_kind;
    logic [3:0]        tok_bit;
    stk_ctrl_t         stk_ctrl;
    logic              eq_res;
    logic              eq_done;
    logic              last_dev;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign wr_en   = accept && (operation == OP_WRITE)
                     && (int'(device) < NUM_DEVICES)
                     && (int'(equation_role) <= OUT_BITS)
                     && (int'(token_position) < MAX_TOKENS);
    assign wr_addr = tok_addr(device, equation_role, POS_W'(token_position));
    assign wr_data = {token_kind, operand_bit};

    assign role_cur  = phase_reg ? (5'(k_reg) + 5'd1) : 5'd0;
    assign load_base = tok_addr(dev_reg, role_cur, '0);

    // next token is fetched while the current one executes
    always_comb
    begin
        if (state_reg == S_LOAD)
        begin
            rd_addr = load_base;
        end
        else if (cnt_reg == POS_W'(MAX_TOKENS - 1))
        begin
            rd_addr = base_reg;
        end
        else
        begin
            rd_addr = base_reg + TS_AW'(cnt_reg) + TS_AW'(1);
        end
    end

    pedc_ram #(
        .WIDTH (TOK_W),
        .DEPTH (STORE_SIZE)
    ) u_token_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign tok_kind = kind_t'(rd_data[6:4]);
    assign tok_bit  = rd_data[3:0];

    always_comb
    begin
        stk_ctrl.clear = (state_reg == S_LOAD);
        stk_ctrl.exec  = (state_reg == S_EVAL) && (tok_kind != K_END);
        stk_ctrl.kind  = tok_kind;
        stk_ctrl.opnd  = addr_reg[tok_bit];
    end

    pedc_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (stk_ctrl),
        .res   (eq_res)
    );

    assign eq_done  = (tok_kind == K_END) || (cnt_reg == POS_W'(MAX_TOKENS - 1));
    assign last_dev = (({1'b0, dev_reg} + 4'd1) == limit_reg);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        dev_next   = dev_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        base_next  = base_reg;
        addr_next  = addr_reg;
        limit_next = limit_reg;
        found_next = found_reg;
        dec_next   = dec_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == OP_RESOLVE))
                begin
                    addr_next  = address & ADDR_MASK;
                    limit_next = (int'(devcnt_reg) > NUM_DEVICES) ? 4'(NUM_DEVICES)
                                                                  : devcnt_reg;
                    phase_next = 1'b0;
                    dev_next   = '0;
                    k_next     = '0;
                    found_next = 1'b0;
                    dec_next   = '0;
                    if (devcnt_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                base_next  = load_base;
                cnt_next   = '0;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cnt_next = cnt_reg + POS_W'(1);
                if (phase_reg && (cnt_reg == '0) && (tok_kind == K_END))
                begin
                    // address equation that starts with end closes the decode
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else if (eq_done)
                begin
                    if (!phase_reg)
                    begin
                        if (eq_res)
                        begin
                            found_next = 1'b1;
                            phase_next = 1'b1;
                            k_next     = '0;
                            state_next = S_LOAD;
                        end
                        else if (last_dev)
                        begin
                            dev_next   = '0;
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            dev_next   = dev_reg + 3'd1;
                            state_next = S_LOAD;
                        end
                    end
                    else
                    begin
                        dec_next[k_reg] = eq_res;
                        if (k_reg == KBIT_W'(OUT_BITS - 1))
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            k_next     = k_reg + KBIT_W'(1);
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= 1'b0;
            dev_reg    <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            limit_reg  <= '0;
            found_reg  <= 1'b0;
            dec_reg    <= '0;
            done_reg   <= 1'b0;
            devcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            dev_reg   <= dev_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            limit_reg <= limit_next;
            found_reg <= found_next;
            dec_reg   <= dec_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                devcnt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        addr_reg <= addr_next;
    end

    assign done            = done_reg;
    assign device_found    = found_reg;
    assign device_index    = dev_reg;
    assign decoded_address = 16'(dec_reg);

    // a result follows either a resolve transfer or the end of a walk
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || (start && operation == OP_RESOLVE)))
        else $error("result strobe without a resolve behind it");

    // a result only appears once the sequencer has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // plain memory result carries zero index and address
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !device_found) |-> (device_index == 3'd0 && decoded_address == 16'd0))
        else $error("no device found but index or address not zero");

    // a resolve with devices to check always leaves idle
    a_resolve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_RESOLVE && devcnt_reg != 4'd0) |=> busy)
        else $error("resolve accepted but sequencer did not start");

endmodule

`default_nettype wire

// ----- hdl/pedc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module pedc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/pedc_stack.sv -----
// one-bit evaluation stack and token execution for postfix equations
// depends on pedc_pkg
`default_nettype none

module pedc_stack
    import pedc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire stk_ctrl_t ctrl,
    output logic           res
);

    // top of stack sits in bit 0, entries above the count are don't-care
    logic [STACK_DEPTH-1:0] stk_reg, stk_next;
    logic [SCNT_W-1:0]      cnt_reg, cnt_next;
    logic                   a, b, r, push_bit;

    always_comb
    begin
        stk_next = stk_reg;
        cnt_next = cnt_reg;
        a        = (cnt_reg >= SCNT_W'(1)) ? stk_reg[0] : 1'b0;
        b        = (cnt_reg >= SCNT_W'(2)) ? stk_reg[1] : 1'b0;
        push_bit = (ctrl.kind == K_OPERAND) ? ctrl.opnd : (ctrl.kind == K_HIGH);
        case (ctrl.kind)
            K_AND:   r = a & b;
            K_OR:    r = a | b;
            default: r = a ^ b;
        endcase

        if (ctrl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctrl.exec)
        begin
            case (ctrl.kind) inside
                K_OPERAND, K_LOW, K_HIGH:
                begin
                    if (cnt_reg < SCNT_W'(STACK_DEPTH))
                    begin
                        stk_next = {stk_reg[STACK_DEPTH-2:0], push_bit};
                        cnt_next = cnt_reg + SCNT_W'(1);
                    end
                    else
                    begin
                        // full: overwrite the top
                        stk_next[0] = push_bit;
                    end
                end
                K_NOT:
                begin
                    if (cnt_reg == '0)
                    begin
                        stk_next[0] = 1'b1;
                        cnt_next    = SCNT_W'(1);
                    end
                    else
                    begin
                        stk_next[0] = ~stk_reg[0];
                    end
                end
                K_AND, K_OR, K_XOR:
                begin
                    if (cnt_reg >= SCNT_W'(2))
                    begin
                        stk_next    = {1'b0, stk_reg[STACK_DEPTH-1:1]};
                        stk_next[0] = r;
                        cnt_next    = cnt_reg - SCNT_W'(1);
                    end
                    else
                    begin
                        // missing operands read as 0
                        stk_next[0] = r;
                        cnt_next    = SCNT_W'(1);
                    end
                end
                default:
                begin
                    stk_next = stk_reg;
                end
            endcase
        end

        res = (cnt_next == '0) ? 1'b0 : stk_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stk_reg <= stk_next;
    end

endmodule

`default_nettype wire
